>>> rtl/core/eamh_pkg.sv
`default_nettype none

package eamh_pkg;

  localparam int COUNT_W = 15;
  localparam int DEG_W   = 8;
  localparam int RAW_W   = 12;
  localparam int NUM_W   = 22;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [COUNT_W-1:0] CPH_MIN   = 15'd30;
  localparam logic [COUNT_W-1:0] CPH_MAX   = 15'd16384;
  localparam logic [COUNT_W-1:0] CPH_RESET = 15'd180;
  localparam logic [DEG_W-1:0]   FULL_SCALE_DEG = 8'd180;
  localparam logic [DEG_W-1:0]   START_DEG      = 8'd90;
  // 4095 / 180 reduces exactly to 91 / 4.
  localparam logic [6:0]         RAW_SCALE      = 7'd91;

  localparam logic [CFG_IDX_W-1:0] CFG_INVERT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CPH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTER  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER  = 2'd3;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_PRESET = 1'b1;

  typedef logic [DEG_W-1:0] deg_t;

endpackage

`default_nettype wire

>>> rtl/core/eamh_if.sv
`default_nettype none

interface eamh_sample_if;
  import eamh_pkg::*;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [COUNT_W-1:0] encoder_count;
  logic [DEG_W-1:0]   preset_deg;
  modport source (output valid, output operation, output encoder_count, output preset_deg,
                  input ready);
  modport sink   (input valid, input operation, input encoder_count, input preset_deg,
                  output ready);
endinterface

interface eamh_result_if;
  import eamh_pkg::*;
  logic             valid;
  logic             ready;
  logic [DEG_W-1:0] angle_deg;
  logic [RAW_W-1:0] angle_raw12;
  modport source (output valid, output angle_deg, output angle_raw12, input ready);
  modport sink   (input valid, input angle_deg, input angle_raw12, output ready);
endinterface

interface eamh_cfg_if;
  import eamh_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/encoder_angle_median_hysteresis.sv
`default_nettype none

// Encoder angle filter: median of three followed by Schmitt hysteresis.
//
// The samples channel carries an operation bit, an encoder count and a preset
// angle. A sample transfer converts the count to whole degrees, pushes it into
// a three-entry ring, takes the median and applies the hysteresis to the
// reported angle. A preset transfer loads the ring and the reported angle.
// Every input transfer produces exactly one transfer on the results channel,
// carrying the reported angle in degrees and a 12-bit raw scaling of it.
//
// The cfg channel writes the four registers (invert, counts per half turn,
// outer and inner threshold); it is always ready and must only be used while
// the block is idle.
//
// A sample passes through the multiply, divide, ring write, median and
// hysteresis steps before the block is ready again; a preset goes straight
// to the final step. The divide step uses the restoring divider, which
// resolves one quotient bit per cycle for all eight quotient bits.
// The result sits in an output register, so a new item is taken while the
// previous result waits; if the receiver stalls for longer, the sequencer
// holds in its final step until the output register frees up.
// Synchronous reset puts the ring at 90 degrees, the reported angle at 90 and
// the registers at their defaults.
module encoder_angle_median_hysteresis
  import eamh_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  eamh_sample_if.sink   samples,
  eamh_result_if.source results,
  eamh_cfg_if.sink      cfg
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MED  = 3'd3;
  localparam logic [2:0] S_SORT = 3'd4;
  localparam logic [2:0] S_HYST = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  // Configuration registers.
  logic               invert;
  logic [COUNT_W-1:0] cph;
  logic [DEG_W-1:0]   outer;
  logic [DEG_W-1:0]   inner;

  // Filter state.
  deg_t       ring [3];
  logic [1:0] slot;
  deg_t       rep;

  logic [2:0]         state;
  logic [COUNT_W-1:0] cph_r;
  logic [COUNT_W-1:0] count_r;
  deg_t               med;

  logic               div_start;
  logic               div_busy;
  logic               div_done;
  deg_t               div_q;
  logic [NUM_W-1:0]   div_num;

  logic               in_xfer;
  logic               out_free;
  logic [COUNT_W-1:0] cph_sat;
  logic [COUNT_W-1:0] count_c;
  deg_t               preset_c;
  deg_t               deg;
  logic [1:0]         wr_idx;
  logic [1:0]         slot_next;
  deg_t               mid3;
  deg_t               inner_eff;
  logic signed [9:0]  med_s;
  logic signed [9:0]  rep_s;
  logic signed [9:0]  outer_s;
  logic signed [9:0]  inner_s;
  logic signed [9:0]  delta;
  logic signed [9:0]  rep_move;
  deg_t               rep_next;
  logic [14:0]        raw_prod;

  assign cfg.ready     = 1'b1;
  assign samples.ready = (state == S_IDLE);
  assign in_xfer       = samples.valid && samples.ready;
  assign out_free      = !results.valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      invert <= 1'b0;
      cph    <= CPH_RESET;
      outer  <= 8'd1;
      inner  <= 8'd0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_INVERT: invert <= cfg.data[0];
        CFG_CPH:    cph    <= cfg.data;
        CFG_OUTER:  outer  <= cfg.data[DEG_W-1:0];
        CFG_INNER:  inner  <= cfg.data[DEG_W-1:0];
        default:    invert <= invert;
      endcase
    end
  end

  // Input conditioning: the resolution is saturated so the divider never
  // sees zero, and the count is clamped to the resolution.
  always_comb begin
    priority if (cph < CPH_MIN) begin
      cph_sat = CPH_MIN;
    end else if (cph > CPH_MAX) begin
      cph_sat = CPH_MAX;
    end else begin
      cph_sat = cph;
    end
    count_c  = (samples.encoder_count > cph_sat) ? cph_sat : samples.encoder_count;
    preset_c = (samples.preset_deg > FULL_SCALE_DEG) ? FULL_SCALE_DEG : samples.preset_deg;
  end

  // Numerator for round-half-up: count * 180 + cph / 2. The product lands in
  // the divider's remainder register.
  assign div_num   = ({{(NUM_W-COUNT_W){1'b0}}, count_r} * NUM_W'(FULL_SCALE_DEG))
                   + {{(NUM_W-COUNT_W+1){1'b0}}, cph_r[COUNT_W-1:1]};
  assign div_start = (state == S_MUL);

  eamh_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (div_num),
    .den      (cph_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // The quotient never exceeds 180, so mirroring needs no further clamp.
  assign deg       = invert ? (FULL_SCALE_DEG - div_q) : div_q;
  // A slot of three cannot occur after reset; it is treated like the wrap.
  assign wr_idx    = (slot == 2'd3) ? 2'd0 : slot;
  assign slot_next = (wr_idx == 2'd2) ? 2'd0 : wr_idx + 2'd1;

  // Median of three by pairwise compares. An entry is the median when it lies
  // between the other two, ties included.
  always_comb begin
    if (((ring[0] >= ring[1]) && (ring[0] <= ring[2])) ||
        ((ring[0] <= ring[1]) && (ring[0] >= ring[2]))) begin
      mid3 = ring[0];
    end else if (((ring[1] >= ring[0]) && (ring[1] <= ring[2])) ||
                 ((ring[1] <= ring[0]) && (ring[1] >= ring[2]))) begin
      mid3 = ring[1];
    end else begin
      mid3 = ring[2];
    end
  end

  // Schmitt hysteresis. A move that clears the outer threshold lands on the
  // median shortened by the inner stickiness, which never exceeds the outer
  // threshold.
  always_comb begin
    inner_eff = (inner > outer) ? outer : inner;
    med_s     = signed'({2'b00, med});
    rep_s     = signed'({2'b00, rep});
    outer_s   = signed'({2'b00, outer});
    inner_s   = signed'({2'b00, inner_eff});
    delta     = med_s - rep_s;
    priority if (delta >= outer_s) begin
      rep_move = med_s - inner_s;
    end else if (delta <= -outer_s) begin
      rep_move = med_s + inner_s;
    end else begin
      rep_move = rep_s;
    end
    priority if (rep_move < 10'sd0) begin
      rep_next = '0;
    end else if (rep_move > 10'sd180) begin
      rep_next = FULL_SCALE_DEG;
    end else begin
      rep_next = rep_move[DEG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ring  <= '{START_DEG, START_DEG, START_DEG};
      slot  <= 2'd0;
      rep   <= START_DEG;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (samples.operation == OP_PRESET) begin
              ring  <= '{preset_c, preset_c, preset_c};
              slot  <= 2'd0;
              rep   <= preset_c;
              state <= S_FIN;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_MED;
          end
        end
        S_MED: begin
          ring[wr_idx] <= deg;
          slot         <= slot_next;
          state        <= S_SORT;
        end
        S_SORT: begin
          state <= S_HYST;
        end
        S_HYST: begin
          rep   <= rep_next;
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Operand and median registers carry payload only.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cph_r   <= cph_sat;
      count_r <= count_c;
    end
    if (state == S_SORT) begin
      med <= mid3;
    end
  end

  // Raw scaling: angle * 4095 / 180 equals angle * 91 / 4, truncated.
  assign raw_prod = {7'b0, rep} * {8'b0, RAW_SCALE};

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      results.angle_deg   <= rep;
      results.angle_raw12 <= raw_prod[RAW_W+1:2];
    end
  end

`ifndef ASSERT_OFF
  a_ready_div_idle: assert property (@(posedge clk) disable iff (rst)
    samples.ready |-> !div_busy)
    else $error("block ready while the divider is still running");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside the divide step");

  a_preset_load: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && samples.operation == OP_PRESET) |=>
      (ring[0] == rep && ring[1] == rep && ring[2] == rep && slot == 2'd0))
    else $error("preset did not load the ring and the reported angle");

  a_rep_range: assert property (@(posedge clk) disable iff (rst)
    rep <= FULL_SCALE_DEG)
    else $error("reported angle above full scale");
`endif

endmodule

`default_nettype wire

>>> rtl/core/eamh_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. The caller guarantees that the
// quotient fits in DEG_W bits, so DEG_W steps suffice.
module eamh_div
  import eamh_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [NUM_W-1:0]   num,
  input  wire logic [COUNT_W-1:0] den,
  output      logic               busy,
  output      logic               done,
  output      logic [DEG_W-1:0]   quotient
);

  logic [NUM_W-1:0]   rem;
  logic [COUNT_W-1:0] den_r;
  logic [2:0]         bit_cnt;
  logic [NUM_W-1:0]   shifted;
  logic               fits;

  assign shifted = {{(NUM_W-COUNT_W){1'b0}}, den_r} << bit_cnt;
  assign fits    = rem >= shifted;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bit_cnt == 3'd0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= num;
      den_r    <= den;
      bit_cnt  <= 3'd7;
      quotient <= '0;
    end else if (busy) begin
      if (fits) begin
        rem               <= rem - shifted;
        quotient[bit_cnt] <= 1'b1;
      end
      bit_cnt <= bit_cnt - 3'd1;
    end
  end

endmodule

`default_nettype wire

>>> verif/encoder_angle_median_hysteresis_test.sv
`timescale 1ns / 1ps

// Testbench for the encoder angle filter: median of three followed by Schmitt
// hysteresis.
//
// Stimulus is driven at the falling clock edge. Every transfer is observed at
// the rising edge. Each accepted input transfer is handed to a scoreboard
// object, which predicts the angle the block should report and queues it.
// Each result transfer is then compared with the oldest queued angle.
// Configuration writes only happen once the block has drained and settled.
module encoder_angle_median_hysteresis_test;
  import eamh_pkg::*;

  localparam int STALL_LIMIT = 2000;  // cycles without any transfer before giving up
  localparam int LONG_HOLD   = 300;   // length of the deliberate result back-pressure
  localparam int SETTLE      = 24;    // quiet cycles before register writes and at the end
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 80;

  typedef struct packed {
    deg_t             deg;
    logic [RAW_W-1:0] raw;
  } angle_pair_t;

  // The scoreboard keeps a private copy of the filter state and of the
  // registers. It predicts one reported angle per accepted input transfer.
  class angle_scoreboard;
    bit          invert;
    int unsigned counts;
    int unsigned outer_thr;
    int unsigned inner_thr;
    int unsigned ring[3];
    int unsigned slot;
    int unsigned reported;
    angle_pair_t angle_due_q[$];
    int          errors;

    function new();
      invert    = 1'b0;
      counts    = CPH_RESET;
      outer_thr = 1;
      inner_thr = 0;
      foreach (ring[i]) ring[i] = START_DEG;
      slot      = 0;
      reported  = START_DEG;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_INVERT: invert    = value[0];
        CFG_CPH:    counts    = value;
        CFG_OUTER:  outer_thr = value[DEG_W-1:0];
        CFG_INNER:  inner_thr = value[DEG_W-1:0];
        default: ;
      endcase
    endfunction

    // Resolution as the block uses it, saturated so the division is never by zero.
    function int unsigned resolution();
      if (counts < CPH_MIN) return CPH_MIN;
      if (counts > CPH_MAX) return CPH_MAX;
      return counts;
    endfunction

    function int pending();
      return angle_due_q.size();
    endfunction

    // Notes an accepted input transfer and queues the angle it must produce.
    function void take_item(logic op, logic [COUNT_W-1:0] count, logic [DEG_W-1:0] preset);
      int unsigned res;
      int unsigned clipped;
      int unsigned lo;
      int unsigned hi;
      int          deg;
      int          med;
      int          delta;
      int          inner;
      int          rep;
      angle_pair_t due;
      if (op == OP_PRESET) begin
        deg = (preset > FULL_SCALE_DEG) ? FULL_SCALE_DEG : preset;
        foreach (ring[i]) ring[i] = deg;
        slot     = 0;
        reported = deg;
      end else begin
        res     = resolution();
        clipped = (count > res) ? res : count;
        deg     = (clipped * FULL_SCALE_DEG + res / 2) / res;
        if (invert) deg = FULL_SCALE_DEG - deg;
        ring[slot] = deg;
        slot = (slot >= 2) ? 0 : slot + 1;
        lo  = (ring[0] < ring[1]) ? ring[0] : ring[1];
        hi  = (ring[0] < ring[1]) ? ring[1] : ring[0];
        med = (ring[2] < lo) ? lo : ((ring[2] > hi) ? hi : ring[2]);
        inner = (inner_thr > outer_thr) ? outer_thr : inner_thr;
        rep   = reported;
        delta = med - rep;
        if (delta >= int'(outer_thr)) rep += delta - inner;
        else if (delta <= -int'(outer_thr)) rep += delta + inner;
        if (rep < 0) rep = 0;
        if (rep > FULL_SCALE_DEG) rep = FULL_SCALE_DEG;
        reported = rep;
      end
      due.deg = reported;
      due.raw = (reported * 4095) / FULL_SCALE_DEG;
      angle_due_q.push_back(due);
    endfunction

    function void check_angle(deg_t deg, logic [RAW_W-1:0] raw);
      angle_pair_t due;
      if (angle_due_q.size() == 0) begin
        $error("unexpected result transfer: angle_deg %0d angle_raw12 %0d", deg, raw);
        errors++;
        return;
      end
      due = angle_due_q.pop_front();
      if (deg !== due.deg) begin
        $error("angle_deg mismatch: expected %0d, actual %0d", due.deg, deg);
        errors++;
      end
      if (raw !== due.raw) begin
        $error("angle_raw12 mismatch: expected %0d, actual %0d", due.raw, raw);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  eamh_sample_if samples();
  eamh_result_if results();
  eamh_cfg_if    cfg();

  encoder_angle_median_hysteresis DUT (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .results (results),
    .cfg     (cfg)
  );

  angle_scoreboard board = new();

  // When calm is set, neither side inserts idle cycles any more. A request for
  // a long hold is picked up by the receiver at its next falling edge.
  bit calm          = 1'b0;
  bit long_hold_req = 1'b0;
  int idle_cycles   = 0;
  int walk_pos      = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  // Result receiver: ready is held low in short random bursts, and once for a
  // long stretch so that the block fills up and has to stall its input.
  initial begin
    results.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        results.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if (!calm && $urandom_range(0, 5) == 0) begin
        results.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      results.ready <= 1'b1;
    end
  end

  // Every result transfer is checked against the oldest predicted angle.
  always @(posedge clk) begin
    if (!rst && results.valid && results.ready) begin
      board.check_angle(results.angle_deg, results.angle_raw12);
    end
  end

  // The watchdog counts cycles in which no transfer of any kind happens.
  always @(posedge clk) begin
    if (rst || (samples.valid && samples.ready) || (results.valid && results.ready)
        || (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Offers one item and returns at the falling edge after its transfer, with
  // valid still high so that a following item can go out back to back.
  task automatic offer(input logic op, input logic [COUNT_W-1:0] count,
                       input logic [DEG_W-1:0] preset);
    if (!calm && $urandom_range(0, 4) == 0) begin
      samples.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    samples.valid         <= 1'b1;
    samples.operation     <= op;
    samples.encoder_count <= count;
    samples.preset_deg    <= preset;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
    board.take_item(op, count, preset);
    @(negedge clk);
  endtask

  // Stops offering and waits until every predicted angle has been delivered.
  task automatic drain();
    samples.valid <= 1'b0;
    do @(negedge clk); while (board.pending() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    board.write_reg(idx, value);
    @(negedge clk);
  endtask

  // Registers may only change while the block is idle, so the pipeline is
  // drained and given time to settle before the four writes go out.
  task automatic configure(input logic inv, input logic [CFG_DATA_W-1:0] counts,
                           input logic [DEG_W-1:0] outer, input logic [DEG_W-1:0] inner);
    drain();
    repeat (SETTLE) @(negedge clk);
    write_reg(CFG_INVERT, CFG_DATA_W'(inv));
    write_reg(CFG_CPH, counts);
    write_reg(CFG_OUTER, CFG_DATA_W'(outer));
    write_reg(CFG_INNER, CFG_DATA_W'(inner));
    cfg.valid <= 1'b0;
  endtask

  // Picks a setting: mostly moderate resolutions and small thresholds, where
  // the hysteresis is actually visible, but now and then a saturating
  // resolution or threshold values beyond their sensible range.
  task automatic random_config();
    logic [CFG_DATA_W-1:0] counts;
    logic [DEG_W-1:0]      outer;
    logic [DEG_W-1:0]      inner;
    case ($urandom_range(0, 9))
      0:       counts = $urandom_range(0, CPH_MIN - 1);
      1:       counts = $urandom_range(CPH_MAX + 1, 32767);
      2:       counts = CPH_MAX;
      3:       counts = CPH_MIN;
      default: counts = $urandom_range(CPH_MIN, 600);
    endcase
    outer = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
    inner = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, outer);
    configure($urandom_range(0, 1), counts, outer, inner);
  endtask

  // Random items: most follow a slow walk of the encoder position, as a real
  // shaft would, so that the median and the thresholds get exercised; the rest
  // are presets and counts anywhere in the field's range.
  task automatic random_phase(input int n_items, input bit with_hold, input bit with_pause);
    int unsigned span;
    int unsigned step;
    int unsigned pick;
    logic [COUNT_W-1:0] count;
    logic [DEG_W-1:0]   preset;
    logic               op;
    span     = board.resolution();
    step     = span / 16 + 1;
    walk_pos = $urandom_range(0, span);
    for (int i = 0; i < n_items; i++) begin
      if (with_hold && i == n_items / 3) long_hold_req = 1'b1;
      if (with_pause && i == n_items / 2) drain();
      pick   = $urandom_range(0, 99);
      op     = OP_SAMPLE;
      count  = $urandom_range(0, 32767);
      preset = $urandom_range(0, 255);
      if (pick < 8) begin
        op = OP_PRESET;
        if ($urandom_range(0, 9) != 0) preset = $urandom_range(0, FULL_SCALE_DEG);
      end else if (pick >= 20) begin
        walk_pos += int'($urandom_range(0, 2 * step)) - int'(step);
        if (walk_pos < 0) walk_pos = 0;
        if (walk_pos > int'(span + span / 8)) walk_pos = span + span / 8;
        count = walk_pos;
      end
      offer(op, count, preset);
    end
  endtask

  initial begin
    samples.valid         = 1'b0;
    samples.operation     = OP_SAMPLE;
    samples.encoder_count = '0;
    samples.preset_deg    = '0;
    cfg.valid             = 1'b0;
    cfg.index             = CFG_INVERT;
    cfg.data              = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part at the reset settings: the ends of the count range, a
    // count above the resolution, a preset above full scale, and a few
    // samples that move the median one way and then back.
    offer(OP_SAMPLE, 15'd0, 8'd0);
    offer(OP_SAMPLE, 15'd180, 8'd255);
    offer(OP_SAMPLE, 15'd200, 8'd0);
    offer(OP_SAMPLE, 15'h7fff, 8'hff);
    offer(OP_PRESET, 15'd0, 8'd255);
    offer(OP_PRESET, 15'h7fff, 8'd0);
    offer(OP_SAMPLE, 15'd1, 8'd0);
    offer(OP_SAMPLE, 15'd1, 8'd0);
    offer(OP_SAMPLE, 15'd1, 8'd0);
    offer(OP_PRESET, 15'd0, 8'd180);
    offer(OP_SAMPLE, 15'd90, 8'd0);
    offer(OP_SAMPLE, 15'd89, 8'd0);

    // Mirrored direction, a resolution of zero that must saturate upwards,
    // a zero outer threshold and an inner stickiness larger than the outer.
    configure(1'b1, 15'd0, 8'd0, 8'd255);
    offer(OP_SAMPLE, 15'd15, 8'd0);
    offer(OP_SAMPLE, 15'd0, 8'd0);
    offer(OP_SAMPLE, 15'd30, 8'd0);
    offer(OP_SAMPLE, 15'd16384, 8'd0);
    offer(OP_PRESET, 15'd0, 8'd45);
    offer(OP_SAMPLE, 15'd7, 8'd0);

    // Resolution above the maximum, and thresholds at full scale.
    configure(1'b0, 15'h7fff, 8'd180, 8'd180);
    offer(OP_SAMPLE, 15'd16384, 8'd0);
    offer(OP_SAMPLE, 15'h7fff, 8'd0);
    offer(OP_SAMPLE, 15'd8192, 8'd0);
    offer(OP_PRESET, 15'd0, 8'd0);
    offer(OP_SAMPLE, 15'd16384, 8'd0);
    offer(OP_SAMPLE, 15'd16384, 8'd0);

    // Random phases, each under its own setting. The second one includes the
    // long result hold-off, the third a pause in which everything drains, and
    // the last runs with no idling on either side.
    for (int p = 0; p < RAND_PHASES; p++) begin
      random_config();
      if (p == RAND_PHASES - 1) calm = 1'b1;
      random_phase(PHASE_ITEMS, p == 1, p == 2);
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> encoder_angle_median_hysteresis.f
rtl/core/eamh_pkg.sv
rtl/core/eamh_if.sv
rtl/core/eamh_div.sv
rtl/core/encoder_angle_median_hysteresis.sv
verif/encoder_angle_median_hysteresis_test.sv
